FILE: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants shared by the peak threshold segmenter modules.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int CHANNELS      = 4;
    localparam int RING_DEPTH    = 256;
    localparam int RING_W        = $clog2(RING_DEPTH);
    localparam int LANES_CARRIED = 4;
    localparam int LANES         = (CHANNELS < LANES_CARRIED) ? CHANNELS : LANES_CARRIED;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int POS_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = LANES_CARRIED * SAMPLE_W;
    localparam int OUT_DATA_W = 56;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [COUNT_W-1:0]         COUNT_MAX  = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        PH_QUIET  = 2'd0,
        PH_SEARCH = 2'd1,
        PH_RECOG  = 2'd2
    } t_phase;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_RESTART = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH      = 3'd0,
        CFG_MAX_LENGTH      = 3'd1,
        CFG_PEAK_THRESHOLD  = 3'd2,
        CFG_USE_MAGNITUDE   = 3'd3,
        CFG_ACTIVE_CHANNELS = 3'd4
    } t_cfg_index;

    // Lane or merged candidate: hit means it beats the stored peak
    typedef struct packed {
        logic                       hit;
        logic signed [SAMPLE_W-1:0] val;
    } t_cand;

endpackage

FILE: design/pts_lane.sv
// ----------------------------------------------------------------------------
// pts_lane
// One channel lane: optional saturating magnitude, compare against the peak.
// ----------------------------------------------------------------------------
module pts_lane (
    input  logic                                 i_enable,
    input  logic                                 i_use_mag,
    input  logic signed [pts_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic signed [pts_pkg::SAMPLE_W-1:0]  i_peak,
    output pts_pkg::t_cand                       o_cand
);

    logic signed [pts_pkg::SAMPLE_W-1:0] w_val;

    always_comb begin
        w_val = i_sample;
        if (i_use_mag && i_sample[pts_pkg::SAMPLE_W-1]) begin
            // the most negative value has no positive twin: saturate
            if (i_sample == pts_pkg::SAMPLE_MIN) begin
                w_val = pts_pkg::SAMPLE_MAX;
            end else begin
                w_val = -i_sample;
            end
        end
        o_cand.val = w_val;
        o_cand.hit = i_enable && (w_val > i_peak);
    end

endmodule

FILE: design/pts_merge.sv
// ----------------------------------------------------------------------------
// pts_merge
// Combine lane candidates into the largest one that beats the peak.
// ----------------------------------------------------------------------------
module pts_merge (
    input  pts_pkg::t_cand i_cand [pts_pkg::LANES],
    output pts_pkg::t_cand o_cand
);

    always_comb begin
        o_cand.hit = 1'b0;
        o_cand.val = pts_pkg::SAMPLE_MIN;
        for (int i = 0; i < pts_pkg::LANES; i++) begin
            if (i_cand[i].hit && (!o_cand.hit || (i_cand[i].val > o_cand.val))) begin
                o_cand.hit = 1'b1;
                o_cand.val = i_cand[i].val;
            end
        end
    end

endmodule

FILE: design/peak_threshold_segmenter.sv
// ----------------------------------------------------------------------------
// peak_threshold_segmenter
// Each beat's result is registered and shown on the master side the next cycle.
// Throughput: one item per cycle while the master keeps up, since the output
// register frees the input. Compare, merge and threshold decision: combinational.
// Reset (synchronous, active low): phase quiet, count and window start zero,
// peak at the most negative value, registers at their documented defaults.
// ----------------------------------------------------------------------------
module peak_threshold_segmenter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: sample_a, sample_b, sample_c, sample_d (16 bits each, lowest first)
    input  logic [pts_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // tuser: opcode
    input  logic                                i_s_axis_tuser,
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: segment_ready[0], window_start[8:1], segment_length[24:9],
    //        read_position[32:25], peak_value[48:33], phase[50:49], zeros above
    output logic [pts_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SW = pts_pkg::SAMPLE_W;
    localparam int CW = pts_pkg::COUNT_W;
    localparam int RW = pts_pkg::RING_W;

    // configuration
    logic [CW-1:0]        r_min_length;
    logic [CW-1:0]        r_max_length;
    logic signed [SW-1:0] r_peak_threshold;
    logic                 r_use_mag;
    logic [2:0]           r_active_ch;

    // segment state
    pts_pkg::t_phase      r_phase, n_phase;
    logic [CW-1:0]        r_length, n_length;
    logic [RW-1:0]        r_window, n_window;
    logic signed [SW-1:0] r_peak, n_peak;
    logic [CW-1:0]        r_peak_index, n_peak_index;

    // output register
    logic                          r_m_valid;
    logic [pts_pkg::OUT_DATA_W-1:0] r_m_tdata, n_m_tdata;

    logic           w_accept;
    logic [CW-1:0]  w_length_inc;
    logic [RW-1:0]  w_read_pos;
    pts_pkg::t_cand w_lane_cand [pts_pkg::LANES];
    pts_pkg::t_cand w_merged;
    logic signed [SW-1:0] w_search_peak;
    logic [CW-1:0]        w_search_index;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length     <= '0;
            r_max_length     <= CW'(1);
            r_peak_threshold <= '0;
            r_use_mag        <= 1'b0;
            r_active_ch      <= 3'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pts_pkg::CFG_MIN_LENGTH:      r_min_length     <= i_cfg_data;
                pts_pkg::CFG_MAX_LENGTH:      r_max_length     <= i_cfg_data;
                pts_pkg::CFG_PEAK_THRESHOLD:  r_peak_threshold <= i_cfg_data;
                pts_pkg::CFG_USE_MAGNITUDE:   r_use_mag        <= i_cfg_data[0];
                pts_pkg::CFG_ACTIVE_CHANNELS: r_active_ch      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // one lane per carried channel; lane i is examined when i < active_channels
    for (genvar g = 0; g < pts_pkg::LANES; g++) begin : g_lane
        pts_lane u_lane (
            .i_enable  (r_active_ch > 3'(g)),
            .i_use_mag (r_use_mag),
            .i_sample  (i_s_axis_tdata[g*SW +: SW]),
            .i_peak    (r_peak),
            .o_cand    (w_lane_cand[g])
        );
    end

    pts_merge u_merge (
        .i_cand (w_lane_cand),
        .o_cand (w_merged)
    );

    assign w_length_inc   = (r_length == pts_pkg::COUNT_MAX) ? r_length : r_length + CW'(1);
    assign w_search_peak  = w_merged.hit ? w_merged.val : r_peak;
    assign w_search_index = w_merged.hit ? w_length_inc : r_peak_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= pts_pkg::PH_QUIET;
            r_length     <= '0;
            r_window     <= '0;
            r_peak       <= pts_pkg::SAMPLE_MIN;
            r_peak_index <= '0;
        end else begin
            r_phase      <= n_phase;
            r_length     <= n_length;
            r_window     <= n_window;
            r_peak       <= n_peak;
            r_peak_index <= n_peak_index;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_length     = r_length;
        n_window     = r_window;
        n_peak       = r_peak;
        n_peak_index = r_peak_index;
        if (w_accept) begin
            if (i_s_axis_tuser == pts_pkg::OP_RESTART) begin
                // advance the window past the segment, clear length and peak, back to quiet
                n_window = r_window + RW'(r_length);
                n_length = '0;
                n_phase  = pts_pkg::PH_QUIET;
                n_peak   = pts_pkg::SAMPLE_MIN;
            end else begin
                unique case (r_phase)
                    pts_pkg::PH_QUIET: begin
                        n_length = w_length_inc;
                        if (w_length_inc > r_min_length) begin
                            n_phase = pts_pkg::PH_SEARCH;
                        end
                    end
                    pts_pkg::PH_SEARCH: begin
                        n_peak       = w_search_peak;
                        n_peak_index = w_search_index;
                        n_length     = w_length_inc;
                        if (w_length_inc >= r_max_length) begin
                            n_length = (w_search_peak > r_peak_threshold) ?
                                       w_search_index : r_min_length;
                            n_phase  = pts_pkg::PH_RECOG;
                        end
                    end
                    default: ;  // recognized: hold until restart
                endcase
            end
        end
    end

    assign w_read_pos = n_window + RW'(n_length);

    always_comb begin
        n_m_tdata        = '0;
        n_m_tdata[0]     = (n_phase == pts_pkg::PH_RECOG);
        n_m_tdata[8:1]   = pts_pkg::POS_W'(n_window);
        n_m_tdata[24:9]  = n_length;
        n_m_tdata[32:25] = pts_pkg::POS_W'(w_read_pos);
        n_m_tdata[48:33] = n_peak;
        n_m_tdata[50:49] = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_m_valid <= i_s_axis_tvalid;
        end
    end

    // hold the result beat while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tdata <= n_m_tdata;
        end
    end

endmodule

FILE: tb/tb_peak_threshold_segmenter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_peak_threshold_segmenter
// Self-checking bench for the segmenter. A directed part covers the sample
// extremes, restarts in every phase, lane clamping, the magnitude repair and
// threshold edges. It is followed by random segments under several register
// settings. A local model of the phase machine predicts every status beat,
// and each beat is checked field by field. Both stream sides idle at random,
// and the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_peak_threshold_segmenter;

    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 64;
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        t_opcode                op;
        logic [IN_DATA_W-1:0]   lanes;
    } t_sensor_item;

    typedef struct packed {
        logic [OUT_DATA_W-52:0]     pad;
        t_phase                     phase;
        logic signed [SAMPLE_W-1:0] peak;
        logic [POS_W-1:0]           rd_pos;
        logic [COUNT_W-1:0]         seg_len;
        logic [POS_W-1:0]           win_start;
        logic                       seg_ready;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_valid = 1'b0;
    t_opcode               s_op = OP_SAMPLE;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_cfg_ready;

    // Register copies, as written
    logic [COUNT_W-1:0]         cfg_min = '0;
    logic [COUNT_W-1:0]         cfg_max = COUNT_W'(1);
    logic signed [SAMPLE_W-1:0] cfg_thr = '0;
    logic                       cfg_mag = 1'b0;
    logic [2:0]                 cfg_lanes = 3'd1;

    // Segmenter state as predicted
    t_phase                     cur_phase = PH_QUIET;
    logic [COUNT_W-1:0]         seg_count = '0;
    logic [POS_W-1:0]           win_base = '0;
    logic signed [SAMPLE_W-1:0] peak_hold = SAMPLE_MIN;
    logic [COUNT_W-1:0]         peak_at = '0;

    t_sensor_item queued_samples[$];
    t_status      predicted_status[$];

    int items_queued = 0;
    int items_taken = 0;
    int reports_checked = 0;
    int mismatches = 0;
    int decisions = 0;
    int restarts = 0;
    int reg_writes = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic [31:0] cycle_cnt = '0;

    // Periodic stretches in which neither side starts a new random idle
    wire burst_window = (cycle_cnt[10:9] == 2'b11);

    peak_threshold_segmenter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_op),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [COUNT_W-1:0] sat_incr(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

    function automatic t_status advance_segmenter(input t_sensor_item it);
        int lanes;
        int v;
        int i;
        t_status st;
        if (it.op == OP_RESTART) begin
            win_base = POS_W'((int'(win_base) + int'(seg_count)) % RING_DEPTH);
            seg_count = '0;
            cur_phase = PH_QUIET;
            peak_hold = SAMPLE_MIN;
            restarts++;
        end else if (cur_phase == PH_QUIET) begin
            seg_count = sat_incr(seg_count);
            if (seg_count > cfg_min) cur_phase = PH_SEARCH;
        end else if (cur_phase == PH_SEARCH) begin
            lanes = cfg_lanes;
            if (lanes > CHANNELS) lanes = CHANNELS;
            if (lanes > LANES_CARRIED) lanes = LANES_CARRIED;
            for (i = 0; i < lanes; i++) begin
                v = $signed(it.lanes[i*SAMPLE_W +: SAMPLE_W]);
                if (cfg_mag) begin
                    if (v < 0) v = -v;
                    // the most negative value has no positive twin: clip it
                    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                end
                if (v > peak_hold) begin
                    peak_hold = SAMPLE_W'(v);
                    peak_at = sat_incr(seg_count);
                end
            end
            seg_count = sat_incr(seg_count);
            if (seg_count >= cfg_max) begin
                seg_count = (peak_hold > cfg_thr) ? peak_at : cfg_min;
                cur_phase = PH_RECOG;
                decisions++;
            end
        end
        st = '0;
        st.seg_ready = (cur_phase == PH_RECOG);
        st.win_start = win_base;
        st.seg_len = seg_count;
        st.rd_pos = POS_W'((int'(win_base) + int'(seg_count)) % RING_DEPTH);
        st.peak = peak_hold;
        st.phase = cur_phase;
        return st;
    endfunction

    function automatic int item_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int stall_len();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_lane();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return SAMPLE_W'($urandom_range(0, 8) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input t_opcode op, input int a, input int b, input int c,
                              input int d);
        t_sensor_item it;
        it.op = op;
        it.lanes = {SAMPLE_W'(d), SAMPLE_W'(c), SAMPLE_W'(b), SAMPLE_W'(a)};
        queued_samples.push_back(it);
        items_queued++;
    endtask

    task automatic queue_random(input t_opcode op);
        queue_item(op, rand_lane(), rand_lane(), rand_lane(), rand_lane());
    endtask

    // One segment shaped for the current registers: quiet run, search run,
    // a few ignored samples, then the restart. Some are cut short.
    task automatic queue_segment();
        int quiet_n;
        int search_n;
        int total;
        quiet_n = int'(cfg_min) + 1;
        search_n = (cfg_max > cfg_min) ? int'(cfg_max) - int'(cfg_min) : 1;
        total = quiet_n + search_n + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) total = $urandom_range(0, total);
        for (int k = 0; k < total; k++) begin
            if ($urandom_range(0, 29) == 0) queue_random(OP_RESTART);
            else queue_random(OP_SAMPLE);
        end
        queue_random(OP_RESTART);
    endtask

    // Call at a rising edge; leaves valid high for a following write
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_LENGTH:      cfg_min = data;
            CFG_MAX_LENGTH:      cfg_max = data;
            CFG_PEAK_THRESHOLD:  cfg_thr = data;
            CFG_USE_MAGNITUDE:   cfg_mag = data[0];
            CFG_ACTIVE_CHANNELS: cfg_lanes = data[2:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (reports_checked != items_queued);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: offer queued items with random gaps
    always @(posedge i_clk) begin
        t_sensor_item nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (queued_samples.size() != 0) begin
                nxt = queued_samples.pop_front();
                s_valid <= 1'b1;
                s_op <= nxt.op;
                s_data <= nxt.lanes;
                gap_left = burst_window ? 0 : item_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each input beat, check each status beat, pace tready
    always @(posedge i_clk) begin
        t_sensor_item seen;
        t_status want;
        t_status got;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                seen.op = s_op;
                seen.lanes = s_data;
                predicted_status.push_back(advance_segmenter(seen));
                items_taken++;
            end
            if (o_m_axis_tvalid && m_ready) begin
                got = o_m_axis_tdata;
                if (predicted_status.size() == 0) begin
                    $error("status beat with no prediction pending: %h", o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = predicted_status.pop_front();
                    report_field("segment_ready", want.seg_ready, got.seg_ready);
                    report_field("window_start", want.win_start, got.win_start);
                    report_field("segment_length", want.seg_len, got.seg_len);
                    report_field("read_position", want.rd_pos, got.rd_pos);
                    report_field("peak_value", want.peak, got.peak);
                    report_field("phase", want.phase, got.phase);
                    report_field("tdata padding", want.pad, got.pad);
                    reports_checked++;
                    // back up the input with a long hold-off now and then
                    if (reports_checked == 150 || reports_checked == 350)
                        hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!burst_window && $urandom_range(0, 99) < 20) begin
                stall_left = stall_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_peak_threshold_segmenter NOT OK");
            $finish;
        end
    end

    initial begin
        int phase_start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: one short segment, an ignored sample, a restart
        @(negedge i_clk);
        queue_item(OP_SAMPLE, 0, 0, 0, 0);
        queue_item(OP_SAMPLE, 100, -5, 7, 9);
        queue_item(OP_SAMPLE, 1, 1, 1, 1);
        queue_item(OP_RESTART, -1, -1, -1, -1);

        wait_drained();
        program_register(CFG_MIN_LENGTH, 16'd1);
        program_register(CFG_MAX_LENGTH, 16'd5);
        program_register(CFG_PEAK_THRESHOLD, 16'd100);
        program_register(CFG_USE_MAGNITUDE, 16'd1);
        program_register(CFG_ACTIVE_CHANNELS, 16'd4);
        // indexes past the register list must be ignored
        for (int k = int'(CFG_ACTIVE_CHANNELS) + 1; k < (1 << CFG_IDX_W); k++)
            program_register(CFG_IDX_W'(k), 16'hFFFF);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
        queue_item(OP_RESTART, 32767, 32767, 32767, 32767);
        queue_item(OP_SAMPLE, 0, 0, 0, 0);
        queue_item(OP_SAMPLE, 0, 0, 0, 0);
        queue_item(OP_SAMPLE, -32768, 0, -1, 5);
        queue_item(OP_SAMPLE, 32767, 32767, 32767, 32767);
        queue_item(OP_SAMPLE, -32768, -32768, -32768, -32768);
        queue_item(OP_SAMPLE, 3, 3, 3, 3);
        queue_item(OP_RESTART, 0, 0, 0, 0);
        queue_item(OP_SAMPLE, 7, 7, 7, 7);
        queue_item(OP_SAMPLE, 9, -9, 9, -9);
        queue_item(OP_RESTART, 0, 0, 0, 0);

        // Min not below max, no lanes examined, lowest threshold
        wait_drained();
        program_register(CFG_MIN_LENGTH, 16'd3);
        program_register(CFG_MAX_LENGTH, 16'd2);
        program_register(CFG_PEAK_THRESHOLD, SAMPLE_MIN);
        program_register(CFG_USE_MAGNITUDE, 16'd0);
        program_register(CFG_ACTIVE_CHANNELS, 16'd0);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
        repeat (4) queue_item(OP_SAMPLE, 1, 2, 3, 4);
        queue_item(OP_SAMPLE, 32767, 32767, 32767, 32767);
        queue_item(OP_SAMPLE, 5, 5, 5, 5);
        queue_item(OP_RESTART, 0, 0, 0, 0);

        // Zero max length, lane count above the carried lanes, top threshold
        wait_drained();
        program_register(CFG_MIN_LENGTH, 16'd0);
        program_register(CFG_MAX_LENGTH, 16'd0);
        program_register(CFG_PEAK_THRESHOLD, SAMPLE_MAX);
        program_register(CFG_USE_MAGNITUDE, 16'd1);
        program_register(CFG_ACTIVE_CHANNELS, 16'd7);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
        queue_item(OP_SAMPLE, 0, 0, 0, 0);
        queue_item(OP_SAMPLE, 32767, -32768, 32767, -32768);
        queue_item(OP_RESTART, 0, 0, 0, 0);

        // Random segments under random small settings
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            program_register(CFG_MIN_LENGTH, CFG_DATA_W'($urandom_range(0, 6)));
            program_register(CFG_MAX_LENGTH, CFG_DATA_W'($urandom_range(0, 14)));
            case ($urandom_range(0, 3))
                0: program_register(CFG_PEAK_THRESHOLD, SAMPLE_MIN);
                1: program_register(CFG_PEAK_THRESHOLD, SAMPLE_MAX);
                default: program_register(CFG_PEAK_THRESHOLD, rand_lane());
            endcase
            program_register(CFG_USE_MAGNITUDE, CFG_DATA_W'($urandom_range(0, 1)));
            program_register(CFG_ACTIVE_CHANNELS, CFG_DATA_W'($urandom_range(0, 7)));
            cfg_valid <= 1'b0;
            @(negedge i_clk);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) queue_segment();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d input beats (%0d restarts), %0d status beats checked,",
                 items_taken, restarts, reports_checked);
        $display("%0d segment decisions, %0d register writes under mixed settings.",
                 decisions, reg_writes);
        if (mismatches == 0) begin
            $display("tb_peak_threshold_segmenter OK");
        end else begin
            $display("tb_peak_threshold_segmenter NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/pts_pkg.sv
design/pts_lane.sv
design/pts_merge.sv
design/peak_threshold_segmenter.sv
tb/tb_peak_threshold_segmenter.sv
